// ----- hdl/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg: shared constants and tables for the quaternion to Euler block
// Fixed-point formats, CORDIC arctangent table and pipeline depth helpers.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int unsigned COMP_BITS_DEF     = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // CORDIC datapath after normalisation, magnitudes sit in [2^28, 2^29)
  localparam int unsigned NORM_BIT    = 29;
  localparam int unsigned NORM_LSTEPS = 5;   // left shifts of up to 31
  localparam int unsigned CORDIC_W    = 32;
  localparam int unsigned ACC_W       = 26;  // angle in 1/32768 degree
  localparam int unsigned ATAN_TAB_LEN = 24;
  localparam int          DEG_UNIT    = 32768;

  localparam logic signed [ACC_W-1:0] ACC_90  = ACC_W'(90 * DEG_UNIT);
  localparam logic signed [ACC_W-1:0] ACC_180 = ACC_W'(180 * DEG_UNIT);

  // square root of 2^60 - s^2, s with 30 fraction bits
  localparam int unsigned SIN_FRAC   = 30;
  localparam int unsigned SQ_RAD_W   = 62;
  localparam int unsigned SQ_TOP_BIT = 60;
  localparam int unsigned SQ_STEPS   = 31;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned PITCH_W = 15;
  localparam int          ROLL_LIM  = 23040;
  localparam int          PITCH_LIM = 11520;

  function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:  v = ACC_W'(1474560);
      1:  v = ACC_W'(870484);
      2:  v = ACC_W'(459940);
      3:  v = ACC_W'(233473);
      4:  v = ACC_W'(117189);
      5:  v = ACC_W'(58652);
      6:  v = ACC_W'(29333);
      7:  v = ACC_W'(14667);
      8:  v = ACC_W'(7334);
      9:  v = ACC_W'(3667);
      10: v = ACC_W'(1833);
      11: v = ACC_W'(917);
      12: v = ACC_W'(458);
      13: v = ACC_W'(229);
      14: v = ACC_W'(115);
      15: v = ACC_W'(57);
      16: v = ACC_W'(29);
      17: v = ACC_W'(14);
      18: v = ACC_W'(7);
      19: v = ACC_W'(4);
      20: v = ACC_W'(2);
      21: v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic int unsigned cordic_iters(input int unsigned stages);
    return (stages < ATAN_TAB_LEN) ? stages : ATAN_TAB_LEN;
  endfunction

  // normalise steps + quadrant + iterations + output rounding
  function automatic int unsigned atan_latency(input int unsigned opw,
                                               input int unsigned stages);
    return $clog2(opw) + 1 + NORM_LSTEPS + 1 + cordic_iters(stages) + 1;
  endfunction

endpackage

// ----- hdl/qte_quat_if.sv -----
// ----------------------------------------------------------------------------
// qte_quat_if: quaternion input channel
// Valid/ready handshake carrying the four signed components.
// ----------------------------------------------------------------------------
interface qte_quat_if #(
  parameter int unsigned COMPONENT_BITS = qte_pkg::COMP_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] comp_x;
  logic signed [COMPONENT_BITS-1:0] comp_y;
  logic signed [COMPONENT_BITS-1:0] comp_z;
  logic signed [COMPONENT_BITS-1:0] comp_w;

  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

// ----- hdl/qte_euler_if.sv -----
// ----------------------------------------------------------------------------
// qte_euler_if: Euler angle output channel
// Valid/ready handshake carrying roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
interface qte_euler_if;
  logic                                valid;
  logic                                ready;
  logic signed [qte_pkg::ANGLE_W-1:0]  roll_deg;
  logic signed [qte_pkg::PITCH_W-1:0]  pitch_deg;
  logic signed [qte_pkg::ANGLE_W-1:0]  yaw_deg;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

// ----- hdl/qte_isqrt.sv -----
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined integer square root
// Floor square root of a radicand up to 2^60, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [qte_pkg::SQ_RAD_W-1:0]      rad_i,
  output logic [qte_pkg::CORDIC_W-1:0]      root_o
);
  import qte_pkg::*;

  logic [SQ_RAD_W-1:0] rem_q [SQ_STEPS];
  logic [SQ_RAD_W-1:0] res_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam int unsigned BITPOS = SQ_TOP_BIT - 2 * k;
    logic [SQ_RAD_W-1:0] rem_in, res_in, trial, bit_v, rem_d, res_d;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    always_comb begin
      bit_v = '0;
      bit_v[BITPOS] = 1'b1;
      trial = res_in + bit_v;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + bit_v;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        res_q[k] <= res_d;
      end
    end
  end

  assign root_o = res_q[SQ_STEPS-1][CORDIC_W-1:0];

endmodule

// ----- hdl/qte_atan2.sv -----
// ----------------------------------------------------------------------------
// qte_atan2: pipelined CORDIC arctangent
// Normalises the operand pair, then vectoring CORDIC, then rounds to 1/128 deg.
// ----------------------------------------------------------------------------
module qte_atan2 #(
  parameter int unsigned OPW           = 34,
  parameter int unsigned CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned OUTW          = qte_pkg::ANGLE_W,
  parameter int          LIM           = qte_pkg::ROLL_LIM
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [OPW-1:0]  y_i,
  input  logic signed [OPW-1:0]  x_i,
  output logic signed [OUTW-1:0] ang_o
);
  import qte_pkg::*;

  localparam int unsigned RSTEPS = $clog2(OPW);
  localparam int unsigned NN     = RSTEPS + 1 + NORM_LSTEPS;
  localparam int unsigned NI     = cordic_iters(CORDIC_STAGES);
  localparam int unsigned NF     = NN + 1 + NI;
  localparam logic signed [ACC_W-1:0] LIM_A = ACC_W'(LIM);

  // magnitude at or above 2^b
  function automatic logic big(input logic signed [OPW-1:0] v, input int unsigned b);
    logic signed [OPW-1:0] lim;
    lim    = '0;
    lim[b] = 1'b1;
    return (v >= lim) || (v <= -lim);
  endfunction

  // axis and zero cases bypass the CORDIC
  logic                    fix_in;
  logic signed [ACC_W-1:0] fixa_in;
  logic                    fx_q [NF];
  logic signed [ACC_W-1:0] fa_q [NF];

  always_comb begin
    fix_in = (y_i == '0) || (x_i == '0);
    if (y_i == '0) begin
      fixa_in = (x_i < 0) ? ACC_180 : '0;
    end else begin
      fixa_in = (y_i > 0) ? ACC_90 : -ACC_90;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q[0] <= fix_in;
      fa_q[0] <= fixa_in;
      for (int k = 1; k < NF; k++) begin
        fx_q[k] <= fx_q[k-1];
        fa_q[k] <= fa_q[k-1];
      end
    end
  end

  // normalisation: greedy right shifts, one final right shift, greedy left shifts
  logic signed [OPW-1:0] ny_q [NN];
  logic signed [OPW-1:0] nx_q [NN];

  for (genvar s = 0; s < NN; s++) begin : g_norm
    logic signed [OPW-1:0] y_in, x_in, y_d, x_d;

    if (s == 0) begin : g_first
      assign y_in = y_i;
      assign x_in = x_i;
    end else begin : g_next
      assign y_in = ny_q[s-1];
      assign x_in = nx_q[s-1];
    end

    if (s < RSTEPS) begin : g_rgt
      localparam int unsigned SH = 1 << (RSTEPS - 1 - s);
      logic signed [OPW-1:0] yt, xt;
      logic                  take;
      assign yt   = y_in >>> SH;
      assign xt   = x_in >>> SH;
      assign take = big(yt, NORM_BIT) || big(xt, NORM_BIT);
      assign y_d  = take ? yt : y_in;
      assign x_d  = take ? xt : x_in;
    end else if (s == RSTEPS) begin : g_one
      logic take;
      assign take = big(y_in, NORM_BIT) || big(x_in, NORM_BIT);
      assign y_d  = take ? (y_in >>> 1) : y_in;
      assign x_d  = take ? (x_in >>> 1) : x_in;
    end else begin : g_lft
      localparam int unsigned SH = 1 << (NN - 1 - s);
      logic take;
      assign take = !big(y_in, NORM_BIT - SH) && !big(x_in, NORM_BIT - SH);
      assign y_d  = take ? (y_in <<< SH) : y_in;
      assign x_d  = take ? (x_in <<< SH) : x_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ny_q[s] <= y_d;
        nx_q[s] <= x_d;
      end
    end
  end

  // quadrant fold into the right half plane
  logic signed [CORDIC_W-1:0] ny_t, nx_t;
  logic signed [CORDIC_W-1:0] qy_d, qx_d, qy_q, qx_q;
  logic signed [ACC_W-1:0]    qa_d, qa_q;

  assign ny_t = CORDIC_W'(ny_q[NN-1]);
  assign nx_t = CORDIC_W'(nx_q[NN-1]);

  always_comb begin
    if (nx_t < 0) begin
      if (ny_t >= 0) begin
        qx_d = ny_t;
        qy_d = -nx_t;
        qa_d = ACC_90;
      end else begin
        qx_d = -ny_t;
        qy_d = nx_t;
        qa_d = -ACC_90;
      end
    end else begin
      qx_d = nx_t;
      qy_d = ny_t;
      qa_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qy_q <= qy_d;
      qx_q <= qx_d;
      qa_q <= qa_d;
    end
  end

  // vectoring iterations
  logic signed [CORDIC_W-1:0] cy_q [NI];
  logic signed [CORDIC_W-1:0] cx_q [NI];
  logic signed [ACC_W-1:0]    ca_q [NI];

  for (genvar i = 0; i < NI; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] y_in, x_in, y_d, x_d;
    logic signed [ACC_W-1:0]    a_in, a_d;

    if (i == 0) begin : g_first
      assign y_in = qy_q;
      assign x_in = qx_q;
      assign a_in = qa_q;
    end else begin : g_next
      assign y_in = cy_q[i-1];
      assign x_in = cx_q[i-1];
      assign a_in = ca_q[i-1];
    end

    always_comb begin
      if (y_in >= 0) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        a_d = a_in + atan_entry(i);
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        a_d = a_in - atan_entry(i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cy_q[i] <= y_d;
        cx_q[i] <= x_d;
        ca_q[i] <= a_d;
      end
    end
  end

  // round to 1/128 degree and saturate
  logic signed [ACC_W-1:0] acc_sel, rnd, sat;
  logic signed [OUTW-1:0]  ang_q;

  always_comb begin
    acc_sel = fx_q[NF-1] ? fa_q[NF-1] : ca_q[NI-1];
    rnd     = (acc_sel + ACC_W'(128)) >>> 8;
    if (rnd > LIM_A) begin
      sat = LIM_A;
    end else if (rnd < -LIM_A) begin
      sat = -LIM_A;
    end else begin
      sat = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= sat[OUTW-1:0];
    end
  end

  assign ang_o = ang_q;

endmodule

// ----- hdl/quaternion_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion to ZYX roll, pitch and yaw
// Fixed-point products, square root and three CORDIC arctangent pipelines.
// ----------------------------------------------------------------------------
// Takes one quaternion (x, y, z, w) per clock while the pipe is not stalled
// and returns roll, pitch and yaw in 1/128 degree, one item out per item in,
// in order. The block is a single pipeline with no feedback: a new item may
// enter every cycle unless the pipe stalls. The atan pipelines work on
// operands of AW = max(2*COMPONENT_BITS + 2, 32) bits. The depth is set by the
// 31-stage square root on the pitch path, followed by the operand
// normalisation and the CORDIC iterations. The whole pipe advances together;
// when the output holds an item that is not taken, the pipe stalls and the
// input is not ready. Roll and yaw go straight into their CORDICs and their
// results wait in a short delay line to meet pitch. No normalisation of the
// quaternion is done; atan2(0,0) gives 0, and pitch is clamped to +-90 degree.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int unsigned COMPONENT_BITS = qte_pkg::COMP_BITS_DEF,
  parameter int unsigned CORDIC_STAGES  = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qte_quat_if.sink      quat_i,
  qte_euler_if.source   euler_o
);
  import qte_pkg::*;

  localparam int unsigned CB  = COMPONENT_BITS;
  localparam int unsigned PW  = 2 * CB;          // product / term width
  localparam int unsigned SB  = 2 * CB - 6;      // term fraction bits
  localparam int unsigned AW  = (2 * CB + 2 > CORDIC_W) ? 2 * CB + 2 : CORDIC_W;
  localparam int unsigned SHL = (SB < SIN_FRAC) ? SIN_FRAC - SB : 0;
  localparam int unsigned SHR = (SB >= SIN_FRAC) ? SB - SIN_FRAC : 0;
  localparam int unsigned LAT_ATAN = atan_latency(AW, CORDIC_STAGES);
  localparam int unsigned DL  = 2 + SQ_STEPS;    // roll/yaw wait for pitch
  localparam int unsigned VL  = 4 + SQ_STEPS + LAT_ATAN;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] yaw;
  } angles_t;

  // pipe advance
  logic          en;
  logic          vld_q [VL];

  assign en           = !vld_q[VL-1] || euler_o.ready;
  assign quat_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VL; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= quat_i.valid;
      for (int k = 1; k < VL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: quarter products, floor
  logic signed [PW-1:0] t_wx_q, t_yz_q, t_xx_q, t_yy_q, t_wz_q, t_xy_q, t_zz_q;
  logic signed [PW-1:0] t_wy_q, t_zx_q;

  function automatic logic signed [PW-1:0] term(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return p >>> 2;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_wx_q <= term(quat_i.comp_w, quat_i.comp_x);
      t_yz_q <= term(quat_i.comp_y, quat_i.comp_z);
      t_xx_q <= term(quat_i.comp_x, quat_i.comp_x);
      t_yy_q <= term(quat_i.comp_y, quat_i.comp_y);
      t_wz_q <= term(quat_i.comp_w, quat_i.comp_z);
      t_xy_q <= term(quat_i.comp_x, quat_i.comp_y);
      t_zz_q <= term(quat_i.comp_z, quat_i.comp_z);
      t_wy_q <= term(quat_i.comp_w, quat_i.comp_y);
      t_zx_q <= term(quat_i.comp_z, quat_i.comp_x);
    end
  end

  // stage 2: atan2 operands, clamped sine with 30 fraction bits
  logic signed [AW-1:0]       one_v, roll_y_d, roll_x_d, yaw_y_d, yaw_x_d, py, pyc, s_ext;
  logic signed [AW-1:0]       roll_y_q, roll_x_q, yaw_y_q, yaw_x_q;
  logic signed [CORDIC_W-1:0] sin_q;

  always_comb begin
    one_v     = '0;
    one_v[SB] = 1'b1;
    roll_y_d  = (AW'(t_wx_q) + AW'(t_yz_q)) <<< 1;
    roll_x_d  = one_v - ((AW'(t_xx_q) + AW'(t_yy_q)) <<< 1);
    yaw_y_d   = (AW'(t_wz_q) + AW'(t_xy_q)) <<< 1;
    yaw_x_d   = one_v - ((AW'(t_yy_q) + AW'(t_zz_q)) <<< 1);
    py        = (AW'(t_wy_q) - AW'(t_zx_q)) <<< 1;
    if (py > one_v) begin
      pyc = one_v;
    end else if (py < -one_v) begin
      pyc = -one_v;
    end else begin
      pyc = py;
    end
    s_ext = (pyc <<< SHL) >>> SHR;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_y_q <= roll_y_d;
      roll_x_q <= roll_x_d;
      yaw_y_q  <= yaw_y_d;
      yaw_x_q  <= yaw_x_d;
      sin_q    <= CORDIC_W'(s_ext);
    end
  end

  // stage 3: sine squared; stage 4: radicand
  logic signed [2*CORDIC_W-1:0] sq_full;
  logic [SQ_RAD_W-1:0]          sq_q, rad_q, one60;
  logic signed [CORDIC_W-1:0]   sin3_q, sin4_q;

  always_comb begin
    sq_full           = sin_q * sin_q;
    one60             = '0;
    one60[SQ_TOP_BIT] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q   <= SQ_RAD_W'($unsigned(sq_full));
      sin3_q <= sin_q;
      rad_q  <= one60 - sq_q;
      sin4_q <= sin3_q;
    end
  end

  // cosine by square root, sine delayed alongside
  logic [CORDIC_W-1:0]        root;
  logic signed [CORDIC_W-1:0] sdl_q [SQ_STEPS];

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdl_q[0] <= sin4_q;
      for (int k = 1; k < SQ_STEPS; k++) begin
        sdl_q[k] <= sdl_q[k-1];
      end
    end
  end

  // three arctangent pipelines
  logic signed [ANGLE_W-1:0] roll_a, yaw_a;
  logic signed [PITCH_W-1:0] pitch_a;
  logic signed [AW-1:0]      pitch_y, pitch_x;

  assign pitch_y = AW'(sdl_q[SQ_STEPS-1]);
  assign pitch_x = AW'($signed({1'b0, root}));

  qte_atan2 #(
    .OPW (AW), .CORDIC_STAGES (CORDIC_STAGES), .OUTW (ANGLE_W), .LIM (ROLL_LIM)
  ) u_roll (
    .clk_i (clk_i), .en_i (en), .y_i (roll_y_q), .x_i (roll_x_q), .ang_o (roll_a)
  );

  qte_atan2 #(
    .OPW (AW), .CORDIC_STAGES (CORDIC_STAGES), .OUTW (ANGLE_W), .LIM (ROLL_LIM)
  ) u_yaw (
    .clk_i (clk_i), .en_i (en), .y_i (yaw_y_q), .x_i (yaw_x_q), .ang_o (yaw_a)
  );

  qte_atan2 #(
    .OPW (AW), .CORDIC_STAGES (CORDIC_STAGES), .OUTW (PITCH_W), .LIM (PITCH_LIM)
  ) u_pitch (
    .clk_i (clk_i), .en_i (en), .y_i (pitch_y), .x_i (pitch_x), .ang_o (pitch_a)
  );

  // roll and yaw wait for the square root path
  angles_t rdl_q [DL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rdl_q[0] <= '{roll: roll_a, yaw: yaw_a};
      for (int k = 1; k < DL; k++) begin
        rdl_q[k] <= rdl_q[k-1];
      end
    end
  end

  assign euler_o.valid     = vld_q[VL-1];
  assign euler_o.roll_deg  = rdl_q[DL-1].roll;
  assign euler_o.yaw_deg   = rdl_q[DL-1].yaw;
  assign euler_o.pitch_deg = pitch_a;

`ifndef NO_ASSERTIONS
  a_roll_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    euler_o.valid |-> (euler_o.roll_deg <= ROLL_LIM) && (euler_o.roll_deg >= -ROLL_LIM))
    else $error("roll out of range");

  a_yaw_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    euler_o.valid |-> (euler_o.yaw_deg <= ROLL_LIM) && (euler_o.yaw_deg >= -ROLL_LIM))
    else $error("yaw out of range");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    euler_o.valid |-> (euler_o.pitch_deg <= PITCH_LIM) && (euler_o.pitch_deg >= -PITCH_LIM))
    else $error("pitch out of range");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !euler_o.valid |-> quat_i.ready)
    else $error("input stalled with empty output");
`endif

endmodule
